// ===== hdl/rycc_pkg.sv =====
// rycc_pkg: shared types, constants and helper functions for the RGB to YCbCr 4:2:0 converter.
// Used by every module in hdl/. No dependencies.
`timescale 1ns / 1ps

package rycc_pkg;

   localparam int MAX_WIDTH   = 4096;
   localparam int MAX_HEIGHT  = 4096;
   localparam int COUNT_SPAN  = 4096;
   localparam int WIDTH_LIMIT  = (MAX_WIDTH  < COUNT_SPAN) ? MAX_WIDTH  : COUNT_SPAN;
   localparam int HEIGHT_LIMIT = (MAX_HEIGHT < COUNT_SPAN) ? MAX_HEIGHT : COUNT_SPAN;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // Q0.16 coefficients
   localparam logic [16:0] K_Y_R  = 17'd19595;
   localparam logic [16:0] K_Y_G  = 17'd38470;
   localparam logic [16:0] K_Y_B  = 17'd7471;
   localparam logic [16:0] K_CB_R = 17'd11058;
   localparam logic [16:0] K_CB_G = 17'd21710;
   localparam logic [16:0] K_CB_B = 17'd32768;
   localparam logic [16:0] K_CR_R = 17'd32768;
   localparam logic [16:0] K_CR_G = 17'd27439;
   localparam logic [16:0] K_CR_B = 17'd5329;
   localparam logic [23:0] K_OFFSET = 24'd8388608;

   localparam logic [12:0] WIDTH_RESET  = 13'd1920;
   localparam logic [12:0] HEIGHT_RESET = 13'd1080;

   typedef enum logic [0:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic        chroma_valid;
      logic [11:0] column;
      logic [11:0] row;
      logic        frame_end;
   } item_type;

   typedef struct packed {
      logic [24:0] y_r;
      logic [24:0] y_g;
      logic [24:0] y_b;
      logic [24:0] cb_r;
      logic [24:0] cb_g;
      logic [24:0] cb_b;
      logic [24:0] cr_r;
      logic [24:0] cr_g;
      logic [24:0] cr_b;
      logic        chroma_valid;
      logic [11:0] column;
      logic [11:0] row;
      logic        frame_end;
   } prod_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [12:0] eff_size(input logic [12:0] v, input logic [12:0] limit);
      logic [12:0] r;
      r = v;
      if (r == 13'd0) begin
         r = 13'd1;
      end
      if (r > limit) begin
         r = limit;
      end
      return r;
   endfunction

   // truncate Q16 accumulator to a byte, clamped to 0..255
   function automatic logic [7:0] to_byte(input logic [26:0] acc);
      logic [7:0] r;
      if (acc[26]) begin
         r = 8'd0;
      end else if (|acc[25:24]) begin
         r = 8'hFF;
      end else begin
         r = acc[23:16];
      end
      return r;
   endfunction

endpackage

// ===== hdl/rycc_front.sv =====
// rycc_front: frame size registers, column/row counters and request classification.
// Depends on rycc_pkg. Pushes classified requests into rycc_queue.
`timescale 1ns / 1ps

module rycc_front
   import rycc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_red,
   input  logic [7:0]       req_green,
   input  logic [7:0]       req_blue,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [0:0]       csr_index,
   input  logic [12:0]      csr_data,
   input  queue_status_type q_status,
   output logic             push,
   output item_type         push_item
);

   logic [12:0] width_ff, width_in;
   logic [12:0] height_ff, height_in;
   logic [11:0] column_ff, column_in;
   logic [11:0] row_ff, row_in;
   logic [12:0] col_inc;
   logic [12:0] row_inc;

   assign csr_ready = 1'b1;
   assign req_ready = !q_status.full;
   assign push      = req_valid && req_ready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:  width_in  = eff_size(csr_data, 13'(WIDTH_LIMIT));
            CSR_FRAME_HEIGHT: height_in = eff_size(csr_data, 13'(HEIGHT_LIMIT));
            default: ;
         endcase
      end
   end

   assign col_inc = {1'b0, column_ff} + 13'd1;
   assign row_inc = {1'b0, row_ff} + 13'd1;

   always_comb begin
      column_in = column_ff;
      row_in    = row_ff;
      if (push) begin
         if (col_inc >= width_ff) begin
            column_in = 12'd0;
            row_in    = (row_inc >= height_ff) ? 12'd0 : row_inc[11:0];
         end else begin
            column_in = col_inc[11:0];
         end
      end
   end

   always_comb begin
      push_item.red          = req_red;
      push_item.green        = req_green;
      push_item.blue         = req_blue;
      push_item.chroma_valid = !column_ff[0] && !row_ff[0]
                               && ({1'b0, column_ff} < (width_ff & ~13'd1))
                               && ({1'b0, row_ff} < (height_ff & ~13'd1));
      push_item.column       = column_ff;
      push_item.row          = row_ff;
      push_item.frame_end    = ({1'b0, column_ff} == width_ff - 13'd1)
                               && ({1'b0, row_ff} == height_ff - 13'd1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         column_ff <= 12'd0;
         row_ff    <= 12'd0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         column_ff <= column_in;
         row_ff    <= row_in;
      end
   end

endmodule

// ===== hdl/rycc_queue.sv =====
// rycc_queue: small register FIFO of classified requests between front and back.
// Depends on rycc_pkg.
`timescale 1ns / 1ps

module rycc_queue
   import rycc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  item_type         push_item,
   input  logic             pop,
   output item_type         pop_item,
   output queue_status_type status
);

   item_type              entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;

   assign status.full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_item     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hdl/rycc_back.sv =====
// rycc_back: two-stage color conversion pipeline (products, then sum/clamp into output reg).
// Depends on rycc_pkg. Pops requests from rycc_queue.
`timescale 1ns / 1ps

module rycc_back
   import rycc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  item_type         pop_item,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_luma,
   output logic [7:0]       rsp_chroma_blue,
   output logic [7:0]       rsp_chroma_red,
   output logic             rsp_chroma_valid,
   output logic [11:0]      rsp_column,
   output logic [11:0]      rsp_row,
   output logic             rsp_frame_end
);

   prod_type    prod_ff, prod_in;
   logic        prod_valid_ff;
   logic        out_valid_ff;
   logic        out_load;
   logic        prod_load;
   logic [26:0] y_acc, cb_acc, cr_acc;
   logic [7:0]  luma_ff, cb_ff, cr_ff;
   logic        cvalid_ff, frame_end_ff;
   logic [11:0] column_ff, row_ff;

   assign out_load  = !out_valid_ff || rsp_ready;
   assign prod_load = !prod_valid_ff || out_load;
   assign pop       = prod_load && !q_status.empty;

   always_comb begin
      prod_in.y_r          = 25'(K_Y_R)  * 25'(pop_item.red);
      prod_in.y_g          = 25'(K_Y_G)  * 25'(pop_item.green);
      prod_in.y_b          = 25'(K_Y_B)  * 25'(pop_item.blue);
      prod_in.cb_r         = 25'(K_CB_R) * 25'(pop_item.red);
      prod_in.cb_g         = 25'(K_CB_G) * 25'(pop_item.green);
      prod_in.cb_b         = 25'(K_CB_B) * 25'(pop_item.blue);
      prod_in.cr_r         = 25'(K_CR_R) * 25'(pop_item.red);
      prod_in.cr_g         = 25'(K_CR_G) * 25'(pop_item.green);
      prod_in.cr_b         = 25'(K_CR_B) * 25'(pop_item.blue);
      prod_in.chroma_valid = pop_item.chroma_valid;
      prod_in.column       = pop_item.column;
      prod_in.row          = pop_item.row;
      prod_in.frame_end    = pop_item.frame_end;
   end

   assign y_acc  = 27'(prod_ff.y_r) + 27'(prod_ff.y_g) + 27'(prod_ff.y_b);
   assign cb_acc = 27'(K_OFFSET) + 27'(prod_ff.cb_b) - 27'(prod_ff.cb_r) - 27'(prod_ff.cb_g);
   assign cr_acc = 27'(K_OFFSET) + 27'(prod_ff.cr_r) - 27'(prod_ff.cr_g) - 27'(prod_ff.cr_b);

   always_ff @(posedge clock) begin
      if (prod_load) begin
         prod_ff <= prod_in;
      end
      if (out_load && prod_valid_ff) begin
         luma_ff      <= to_byte(y_acc);
         cb_ff        <= prod_ff.chroma_valid ? to_byte(cb_acc) : 8'd0;
         cr_ff        <= prod_ff.chroma_valid ? to_byte(cr_acc) : 8'd0;
         cvalid_ff    <= prod_ff.chroma_valid;
         column_ff    <= prod_ff.column;
         row_ff       <= prod_ff.row;
         frame_end_ff <= prod_ff.frame_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (prod_load) begin
            prod_valid_ff <= !q_status.empty;
         end
         if (out_load) begin
            out_valid_ff <= prod_valid_ff;
         end
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_luma         = luma_ff;
   assign rsp_chroma_blue  = cb_ff;
   assign rsp_chroma_red   = cr_ff;
   assign rsp_chroma_valid = cvalid_ff;
   assign rsp_column       = column_ff;
   assign rsp_row          = row_ff;
   assign rsp_frame_end    = frame_end_ff;

endmodule

// ===== hdl/rgb_to_ycbcr_420_converter_top.sv =====
// RGB to full-range BT.601 YCbCr 4:2:0 converter, top level.
// Request path: queue entry written at the accept edge, then product stage, then output reg
// drives rsp_valid; front and back stall independently across the 4-entry queue.
// Throughput: one pixel per cycle unless the output stalls.
// Reset (synchronous, active high): counters to 0, frame size to 1920x1080, pipeline empty.
// Depends on rycc_pkg, rycc_front, rycc_queue, rycc_back.
`timescale 1ns / 1ps

module rgb_to_ycbcr_420_converter_top
   import rycc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_luma,
   output logic [7:0]  rsp_chroma_blue,
   output logic [7:0]  rsp_chroma_red,
   output logic        rsp_chroma_valid,
   output logic [11:0] rsp_column,
   output logic [11:0] rsp_row,
   output logic        rsp_frame_end,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [12:0] csr_data
);

   queue_status_type q_status;
   logic             push;
   logic             pop;
   item_type         push_item;
   item_type         pop_item;

   rycc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_red   (req_red),
      .req_green (req_green),
      .req_blue  (req_blue),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .q_status  (q_status),
      .push      (push),
      .push_item (push_item)
   );

   rycc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .status    (q_status)
   );

   rycc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .pop_item         (pop_item),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_luma         (rsp_luma),
      .rsp_chroma_blue  (rsp_chroma_blue),
      .rsp_chroma_red   (rsp_chroma_red),
      .rsp_chroma_valid (rsp_chroma_valid),
      .rsp_column       (rsp_column),
      .rsp_row          (rsp_row),
      .rsp_frame_end    (rsp_frame_end)
   );

   a_chroma_even: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_chroma_valid |-> !rsp_column[0] && !rsp_row[0])
      else $error("chroma on odd position");

   a_chroma_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_chroma_valid |-> rsp_chroma_blue == 8'd0 && rsp_chroma_red == 8'd0)
      else $error("chroma not zero without chroma_valid");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_status.empty)
      else $error("pop from empty queue");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("push into full queue");

endmodule

// ===== test/tb_top.sv =====
// Self-checking bench for rgb_to_ycbcr_420_converter_top: BT.601 luma, 4:2:0 chroma and
// frame position, predicted per pixel and compared with every response in order.
// Depends on rycc_pkg and the converter RTL.
`timescale 1ns / 1ps

module tb_top;
   import rycc_pkg::*;

   typedef struct packed {
      logic [7:0]  luma;
      logic [7:0]  chroma_blue;
      logic [7:0]  chroma_red;
      logic        chroma_valid;
      logic [11:0] column;
      logic [11:0] row;
      logic        frame_end;
   } ycc_pixel_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_ready;
   logic [7:0]    req_red = '0;
   logic [7:0]    req_green = '0;
   logic [7:0]    req_blue = '0;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   logic [7:0]    rsp_luma;
   logic [7:0]    rsp_chroma_blue;
   logic [7:0]    rsp_chroma_red;
   logic          rsp_chroma_valid;
   logic [11:0]   rsp_column;
   logic [11:0]   rsp_row;
   logic          rsp_frame_end;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   csr_index_type csr_index = CSR_FRAME_WIDTH;
   logic [12:0]   csr_data = '0;

   // model state
   logic [12:0]   cfg_width = WIDTH_RESET;
   logic [12:0]   cfg_height = HEIGHT_RESET;
   logic [11:0]   col_count = '0;
   logic [11:0]   row_count = '0;
   ycc_pixel_type expected_pixels[$];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int mismatch_count = 0;
   int pixels_sent = 0;
   int pixels_checked = 0;
   int chroma_count = 0;
   int frame_end_count = 0;
   int size_changes = 0;

   rgb_to_ycbcr_420_converter_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_red          (req_red),
      .req_green        (req_green),
      .req_blue         (req_blue),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_luma         (rsp_luma),
      .rsp_chroma_blue  (rsp_chroma_blue),
      .rsp_chroma_red   (rsp_chroma_red),
      .rsp_chroma_valid (rsp_chroma_valid),
      .rsp_column       (rsp_column),
      .rsp_row          (rsp_row),
      .rsp_frame_end    (rsp_frame_end),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   always #5 clock = ~clock;

   function automatic int clip_size(input logic [12:0] v, input int limit);
      int s;
      s = (v == 0) ? 1 : int'(v);
      return (s > limit) ? limit : s;
   endfunction

   function automatic logic [7:0] q16_to_byte(input int acc);
      int v;
      if (acc < 0) return 8'd0;
      v = acc >>> 16;
      return (v > 255) ? 8'd255 : v[7:0];
   endfunction

   // Converts one pixel and advances the frame position.
   function automatic ycc_pixel_type convert_pixel(input logic [7:0] r, g, b);
      ycc_pixel_type px;
      int w, h, c, rw, ri, gi, bi;
      w = clip_size(cfg_width, WIDTH_LIMIT);
      h = clip_size(cfg_height, HEIGHT_LIMIT);
      c = int'(col_count);
      rw = int'(row_count);
      ri = int'(r);
      gi = int'(g);
      bi = int'(b);
      px.chroma_valid = !c[0] && !rw[0] && (c < (w & ~1)) && (rw < (h & ~1));
      px.luma = q16_to_byte(19595 * ri + 38470 * gi + 7471 * bi);
      if (px.chroma_valid) begin
         px.chroma_blue = q16_to_byte(8388608 - 11058 * ri - 21710 * gi + 32768 * bi);
         px.chroma_red  = q16_to_byte(8388608 + 32768 * ri - 27439 * gi - 5329 * bi);
      end else begin
         px.chroma_blue = 8'd0;
         px.chroma_red  = 8'd0;
      end
      px.column = c[11:0];
      px.row = rw[11:0];
      px.frame_end = (c == w - 1) && (rw == h - 1);
      c++;
      if (c >= w) begin
         c = 0;
         rw++;
         if (rw >= h) rw = 0;
      end
      col_count = c[11:0];
      row_count = rw[11:0];
      return px;
   endfunction

   task automatic send_pixel(input logic [7:0] r, g, b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_red <= r;
      req_green <= g;
      req_blue <= b;
      do @(posedge clock); while (!req_ready);
      expected_pixels.push_back(convert_pixel(r, g, b));
      pixels_sent++;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_frame_size(input logic [12:0] w, h);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= CSR_FRAME_WIDTH;
      csr_data <= w;
      do @(posedge clock); while (!csr_ready);
      cfg_width = w;
      csr_index <= CSR_FRAME_HEIGHT;
      csr_data <= h;
      do @(posedge clock); while (!csr_ready);
      cfg_height = h;
      csr_valid <= 1'b0;
      size_changes++;
   endtask

   function automatic logic [7:0] random_level();
      if ($urandom_range(7) == 0) return $urandom_range(1) ? 8'd255 : 8'd0;
      return 8'($urandom_range(255));
   endfunction

   function automatic logic [12:0] random_dimension();
      case ($urandom_range(11))
         0: return 13'd0;
         1: return $urandom_range(1) ? 13'd4096 : 13'($urandom_range(4097, 8191));
         default: return 13'($urandom_range(1, 10));
      endcase
   endfunction

   task automatic check_field(input string name, input int exp, input int act);
      if (exp != act) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp, act);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      ycc_pixel_type exp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            $display("%0t: response with no pending request", $time);
            mismatch_count++;
         end else begin
            exp = expected_pixels.pop_front();
            check_field("luma", int'(exp.luma), int'(rsp_luma));
            check_field("chroma_blue", int'(exp.chroma_blue), int'(rsp_chroma_blue));
            check_field("chroma_red", int'(exp.chroma_red), int'(rsp_chroma_red));
            check_field("chroma_valid", int'(exp.chroma_valid), int'(rsp_chroma_valid));
            check_field("column", int'(exp.column), int'(rsp_column));
            check_field("row", int'(exp.row), int'(rsp_row));
            check_field("frame_end", int'(exp.frame_end), int'(rsp_frame_end));
            pixels_checked++;
            if (rsp_chroma_valid) chroma_count++;
            if (rsp_frame_end) frame_end_count++;
         end
      end
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // black, white, primaries and two secondaries (yellow, cyan) at the reset frame size
   task automatic test_color_extremes();
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd255, 8'd0, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd0, 8'd255);
      send_pixel(8'd255, 8'd255, 8'd0);
      send_pixel(8'd0, 8'd255, 8'd255);
   endtask

   task automatic test_degenerate_sizes();
      set_frame_size(13'd1, 13'd1);
      repeat (2) send_pixel(8'd200, 8'd10, 8'd90);
      set_frame_size(13'd0, 13'd0);
      repeat (2) send_pixel(8'd30, 8'd240, 8'd5);
      set_frame_size(13'd3, 13'd2);
      repeat (6) send_pixel(random_level(), random_level(), random_level());
   endtask

   task automatic test_oversize_frame();
      set_frame_size(13'd8191, 13'd4097);
      repeat (3) send_pixel(random_level(), random_level(), random_level());
   endtask

   task automatic test_resize_mid_frame();
      set_frame_size(13'd4, 13'd4);
      repeat (6) send_pixel(random_level(), random_level(), random_level());
      set_frame_size(13'd2, 13'd1);
      repeat (3) send_pixel(random_level(), random_level(), random_level());
   endtask

   task automatic test_random_stream(input int count);
      int target;
      int burst;
      target = pixels_sent + count;
      while (pixels_sent < target) begin
         set_frame_size(random_dimension(), random_dimension());
         burst = $urandom_range(10, 60);
         repeat (burst) send_pixel(random_level(), random_level(), random_level());
      end
   endtask

   initial begin
      #2_000_000;
      $display("tb: failure");
      $finish;
   end

   initial begin
      send_idle_pct = 14;
      recv_stall_pct = 69;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_color_extremes();
      test_degenerate_sizes();
      test_oversize_frame();
      test_resize_mid_frame();
      test_random_stream(430);
      send_idle_pct = 69;
      recv_stall_pct = 14;
      test_random_stream(430);
      send_idle_pct = 0;
      recv_stall_pct = 0;
      test_random_stream(440);
      wait_drained();
      $display("summary: %0d pixels sent, %0d responses checked over %0d frame sizes",
               pixels_sent, pixels_checked, size_changes);
      $display("summary: %0d chroma samples, %0d frame ends, %0d mismatches",
               chroma_count, frame_end_count, mismatch_count);
      if (mismatch_count == 0 && expected_pixels.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== rgb_to_ycbcr_420_converter_top.f =====
hdl/rycc_pkg.sv
hdl/rycc_front.sv
hdl/rycc_queue.sv
hdl/rycc_back.sv
hdl/rgb_to_ycbcr_420_converter_top.sv
test/tb_top.sv
